// ===== hdl/assert_macros.svh =====
// assertion macros used by modbus_rtu_master_transaction
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_NORST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

// ===== hdl/mbrtu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbrtu_pkg
// types, codes and helpers of the modbus rtu master
// ----------------------------------------------------------------------------
package mbrtu_pkg;
   localparam int RxBufferDepth = 256;
   localparam logic [15:0] FrameGapReset = 16'd1750;
   localparam logic [19:0] ReplyTimeoutReset = 20'd1000000;

   localparam logic [1:0] REQ_START = 2'd0;
   localparam logic [1:0] REQ_BYTE  = 2'd1;
   localparam logic [1:0] REQ_TICK  = 2'd2;
   localparam logic [1:0] REQ_READ  = 2'd3;

   localparam logic [1:0] OP_COILS = 2'd0;
   localparam logic [1:0] OP_REGS  = 2'd1;
   localparam logic [1:0] OP_WRITE = 2'd2;

   localparam logic [1:0] KIND_TX   = 2'd0;
   localparam logic [1:0] KIND_STAT = 2'd1;
   localparam logic [1:0] KIND_DATA = 2'd2;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_NORP = 2'd1;
   localparam logic [1:0] ST_MISM = 2'd2;
   localparam logic [1:0] ST_EXC  = 2'd3;

   localparam logic [0:0] CSR_GAP = 1'd0;
   localparam logic [0:0] CSR_TMO = 1'd1;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [7:0]  target_id;
      logic [1:0]  op_kind;
      logic [15:0] start_addr;
      logic [15:0] count_or_value;
      logic [7:0]  rx_byte;
      logic [6:0]  data_index;
   } req_type_type;

   typedef struct packed {
      logic [1:0]  out_kind;
      logic [7:0]  tx_byte;
      logic        last;
      logic [1:0]  status;
      logic [7:0]  exception_code;
      logic [15:0] data_word;
   } rsp_type;

   typedef struct packed {
      logic [0:0]  index;
      logic [19:0] data;
   } csr_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'd0, b};
      for (int k = 0; k < 8; k++)
         c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
      return c;
   endfunction

   function automatic logic [7:0] fcode(input logic [1:0] op);
      logic [7:0] f;
      case (op)
         OP_COILS: f = 8'h01;
         OP_REGS:  f = 8'h03;
         default:  f = 8'h06;
      endcase
      return f;
   endfunction
endpackage

// ===== hdl/mbrtu_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbrtu_req_if / mbrtu_rsp_if / mbrtu_csr_if
// valid/ready channels of the modbus rtu master
// ----------------------------------------------------------------------------
interface mbrtu_req_if;
   logic valid;
   logic ready;
   mbrtu_pkg::req_type_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface mbrtu_rsp_if;
   logic valid;
   logic ready;
   mbrtu_pkg::rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface mbrtu_csr_if;
   logic valid;
   logic ready;
   mbrtu_pkg::csr_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== hdl/mbrtu_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbrtu_ram
// generic single-port-write, single-read ram with registered read
// ----------------------------------------------------------------------------
module mbrtu_ram #(
   parameter int Width = 8,
   parameter int Depth = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data_ff <= mem_ff[rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule

// ===== hdl/modbus_rtu_master_transaction.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modbus_rtu_master_transaction
// modbus rtu master for function codes 01, 03 and 06
// ----------------------------------------------------------------------------
// channel  dir  contents
// req      in   start / rx byte / us tick / read-back
// rsp      out  request bytes, status, read data
// csr      in   frame gap and reply timeout
// a start gives eight request bytes, one per cycle while the output is free,
// with input held off; bytes and ticks are taken in the idle state; a tick
// that ends a frame starts a judge sequence reading the byte ram, then the emit
// a read-back holds off the input for four ram steps (address, byte count and
// two data bytes) and the emit
// reset is synchronous; no ram clearing, entries past the fill count read as
// zero; a result waiting in the output register holds off the input
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module modbus_rtu_master_transaction #(
   parameter int RX_BUFFER_DEPTH = mbrtu_pkg::RxBufferDepth
) (
   input logic clock,
   input logic reset,
   mbrtu_req_if.sink   req,
   mbrtu_rsp_if.source rsp,
   mbrtu_csr_if.sink   csr
);
   localparam int AW = $clog2(RX_BUFFER_DEPTH);
   localparam int CW = AW + 1;

   // phase: 0 idle, 1 awaiting reply, 2 done ok, 3 done failed
   localparam logic [1:0] PH_IDLE = 2'd0, PH_WAIT = 2'd1, PH_OK = 2'd2, PH_FAIL = 2'd3;

   typedef enum logic [2:0] {
      S_IDLE, S_TX, S_JUDGE, S_READ, S_EMIT
   } st_type;

   logic [15:0] gap_ff;
   logic [19:0] tmo_ff;
   st_type      st_ff, st_in;
   logic [1:0]  phase_ff, phase_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [15:0] crc_ff, crc_in;
   logic [19:0] sil_ff, sil_in;
   logic        started_ff, started_in;
   logic [7:0]  lslave_ff, lslave_in;
   logic [1:0]  lop_ff, lop_in;
   logic [15:0] laddr_ff, laddr_in;
   logic [15:0] lcv_ff, lcv_in;
   logic [2:0]  step_ff, step_in;
   logic [7:0]  frame_ff [8];
   logic [7:0]  frame_in [8];
   logic [6:0]  idx_ff, idx_in;
   logic [7:0]  b2_ff, b2_in;
   logic [15:0] word_ff, word_in;
   logic [1:0]  jst_ff, jst_in;
   logic [7:0]  jexc_ff, jexc_in;
   logic        rv_ff, rv_in;
   mbrtu_pkg::rsp_type rp_ff, rp_in;

   logic          wr_en;
   logic [AW-1:0] rd_addr;
   logic [7:0]    rd_data;
   logic [CW-1:0] rd_idx_ff, rd_idx_in;

   mbrtu_ram #(.Width(8), .Depth(RX_BUFFER_DEPTH)) u_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(cnt_ff[AW-1:0]),
      .wr_data(req.payload.rx_byte), .rd_addr(rd_addr), .rd_data(rd_data));

   // byte at the registered read index, zero past the frame
   logic [7:0] rbyte;
   assign rbyte = (rd_idx_ff < cnt_ff) ? rd_data : 8'd0;

   logic out_free, req_acc;
   assign out_free = !rv_ff || rsp.ready;
   assign req.ready = (st_ff == S_IDLE) && out_free;
   assign req_acc = req.valid && req.ready;
   assign csr.ready = 1'b1;
   assign rsp.valid = rv_ff;
   assign rsp.payload = rp_ff;
   assign wr_en = req_acc && req.payload.req_type == mbrtu_pkg::REQ_BYTE
                  && phase_ff == PH_WAIT && cnt_ff < CW'(RX_BUFFER_DEPTH);

   logic [15:0] scrc;
   logic [19:0] sil_nx;
   logic [CW-1:0] cnt_m2;
   logic [15:0] cnt_lim;
   logic [16:0] rq_bc;

   always_comb begin
      st_in = st_ff; phase_in = phase_ff; cnt_in = cnt_ff; crc_in = crc_ff;
      sil_in = sil_ff; started_in = started_ff; lslave_in = lslave_ff;
      lop_in = lop_ff; laddr_in = laddr_ff; lcv_in = lcv_ff; step_in = step_ff;
      frame_in = frame_ff; idx_in = idx_ff; b2_in = b2_ff; word_in = word_ff;
      jst_in = jst_ff; jexc_in = jexc_ff; rd_idx_in = rd_idx_ff;
      rv_in = rv_ff && !rsp.ready; rp_in = rp_ff;
      rd_addr = rd_idx_ff[AW-1:0];
      scrc = 16'hFFFF;
      sil_nx = (sil_ff != 20'hFFFFF) ? sil_ff + 20'd1 : sil_ff;
      cnt_m2 = cnt_ff - CW'(2);
      cnt_lim = {3'd0, lcv_ff[15:3]} + 16'd1;
      rq_bc = {lcv_ff, 1'b0};
      unique case (st_ff)
         S_IDLE: if (req_acc) begin
            unique case (req.payload.req_type)
               mbrtu_pkg::REQ_START: if (req.payload.op_kind != 2'd3) begin
                  frame_in[0] = req.payload.target_id;
                  frame_in[1] = mbrtu_pkg::fcode(req.payload.op_kind);
                  frame_in[2] = req.payload.start_addr[15:8];
                  frame_in[3] = req.payload.start_addr[7:0];
                  frame_in[4] = req.payload.count_or_value[15:8];
                  frame_in[5] = req.payload.count_or_value[7:0];
                  for (int k = 0; k < 6; k++) scrc = mbrtu_pkg::crc_byte(scrc, frame_in[k]);
                  frame_in[6] = scrc[7:0];
                  frame_in[7] = scrc[15:8];
                  lslave_in = req.payload.target_id; lop_in = req.payload.op_kind;
                  laddr_in = req.payload.start_addr; lcv_in = req.payload.count_or_value;
                  cnt_in = '0; crc_in = 16'hFFFF; sil_in = '0; started_in = 1'b0;
                  phase_in = PH_WAIT; step_in = '0; st_in = S_TX;
               end
               mbrtu_pkg::REQ_BYTE: if (phase_ff == PH_WAIT) begin
                  started_in = 1'b1; sil_in = '0;
                  if (cnt_ff >= CW'(RX_BUFFER_DEPTH)) begin
                     phase_in = PH_FAIL; rv_in = 1'b1;
                     rp_in = '{mbrtu_pkg::KIND_STAT, 8'd0, 1'b0, mbrtu_pkg::ST_NORP,
                               8'd0, 16'd0};
                  end else begin
                     crc_in = mbrtu_pkg::crc_byte(crc_ff, req.payload.rx_byte);
                     cnt_in = cnt_ff + CW'(1);
                  end
               end
               mbrtu_pkg::REQ_TICK: if (phase_ff == PH_WAIT) begin
                  sil_in = sil_nx;
                  if (started_ff && sil_nx > {4'd0, gap_ff}) begin
                     if (cnt_ff < CW'(5) || crc_ff != 16'd0) begin
                        phase_in = PH_FAIL; rv_in = 1'b1;
                        rp_in = '{mbrtu_pkg::KIND_STAT, 8'd0, 1'b0,
                                  mbrtu_pkg::ST_NORP, 8'd0, 16'd0};
                     end else begin
                        cnt_in = cnt_m2; step_in = '0; rd_idx_in = '0;
                        rd_addr = '0; st_in = S_JUDGE;
                     end
                  end else if (sil_nx >= tmo_ff) begin
                     phase_in = PH_FAIL; rv_in = 1'b1;
                     rp_in = '{mbrtu_pkg::KIND_STAT, 8'd0, 1'b0,
                               mbrtu_pkg::ST_NORP, 8'd0, 16'd0};
                  end
               end
               default: begin
                  idx_in = req.payload.data_index; step_in = '0;
                  rd_idx_in = CW'(2); rd_addr = AW'(2); st_in = S_READ;
               end
            endcase
         end
         S_TX: if (out_free) begin
            rv_in = 1'b1;
            rp_in = '{mbrtu_pkg::KIND_TX, frame_ff[step_ff], step_ff == 3'd7,
                      mbrtu_pkg::ST_OK, 8'd0, 16'd0};
            step_in = step_ff + 3'd1;
            if (step_ff == 3'd7) st_in = S_IDLE;
         end
         S_JUDGE: begin
            // one frame byte per step; rbyte is byte step_ff
            rd_idx_in = CW'(step_ff) + CW'(1);
            rd_addr = AW'(step_ff) + AW'(1);
            step_in = step_ff + 3'd1;
            unique case (step_ff)
               3'd0: if (rbyte != lslave_ff) begin
                  jst_in = mbrtu_pkg::ST_MISM; st_in = S_EMIT;
               end
               3'd1: begin
                  b2_in = rbyte;
                  if ({1'b0, rbyte[6:0]} != mbrtu_pkg::fcode(lop_ff)) begin
                     jst_in = mbrtu_pkg::ST_MISM; st_in = S_EMIT;
                  end
               end
               3'd2: begin
                  if (b2_ff[7]) begin
                     jst_in = mbrtu_pkg::ST_EXC; jexc_in = rbyte; st_in = S_EMIT;
                  end else if (lop_ff == mbrtu_pkg::OP_COILS) begin
                     jst_in = ({8'd0, rbyte} > cnt_lim) ? mbrtu_pkg::ST_MISM
                                                       : mbrtu_pkg::ST_OK;
                     st_in = S_EMIT;
                  end else if (lop_ff == mbrtu_pkg::OP_REGS) begin
                     jst_in = ({9'd0, rbyte} != rq_bc) ? mbrtu_pkg::ST_MISM
                                                      : mbrtu_pkg::ST_OK;
                     st_in = S_EMIT;
                  end else if (rbyte != laddr_ff[15:8]) begin
                     jst_in = mbrtu_pkg::ST_MISM; st_in = S_EMIT;
                  end
               end
               3'd3: if (rbyte != laddr_ff[7:0]) begin
                  jst_in = mbrtu_pkg::ST_MISM; st_in = S_EMIT;
               end
               3'd4: if (rbyte != lcv_ff[15:8]) begin
                  jst_in = mbrtu_pkg::ST_MISM; st_in = S_EMIT;
               end
               default: begin
                  jst_in = (rbyte != lcv_ff[7:0]) ? mbrtu_pkg::ST_MISM
                                                 : mbrtu_pkg::ST_OK;
                  st_in = S_EMIT;
               end
            endcase
            if (st_in == S_EMIT && jst_in != mbrtu_pkg::ST_EXC) jexc_in = 8'd0;
         end
         S_READ: begin
            // step 0: ram address issued; 1: byte count; 2,3: data bytes
            step_in = step_ff + 3'd1;
            unique case (step_ff)
               3'd0: ;
               3'd1: begin
                  b2_in = rbyte;
                  rd_idx_in = (lop_ff == mbrtu_pkg::OP_REGS) ? CW'(3) + CW'({idx_ff, 1'b0})
                                                            : CW'(3) + CW'(idx_ff);
                  rd_addr = rd_idx_in[AW-1:0];
               end
               3'd2: begin
                  word_in = {8'd0, rbyte};
                  rd_idx_in = rd_idx_ff + CW'(1);
                  rd_addr = rd_idx_in[AW-1:0];
               end
               default: begin
                  if (phase_ff == PH_OK && lop_ff == mbrtu_pkg::OP_COILS
                      && {1'b0, idx_ff} < b2_ff)
                     word_in = word_ff;
                  else if (phase_ff == PH_OK && lop_ff == mbrtu_pkg::OP_REGS
                      && {idx_ff, 1'b1} < b2_ff)
                     word_in = {word_ff[7:0], rbyte};
                  else word_in = 16'd0;
                  jst_in = mbrtu_pkg::ST_OK; st_in = S_EMIT;
               end
            endcase
            if (st_in == S_EMIT) begin
               // read-back uses the emit path with kind data
               jexc_in = 8'hFF;
            end
         end
         default: if (out_free) begin
            rv_in = 1'b1;
            if (jexc_ff == 8'hFF && jst_in == mbrtu_pkg::ST_OK && step_ff == 3'd4)
               rp_in = '{mbrtu_pkg::KIND_DATA, 8'd0, 1'b0, mbrtu_pkg::ST_OK, 8'd0, word_ff};
            else begin
               rp_in = '{mbrtu_pkg::KIND_STAT, 8'd0, 1'b0, jst_ff,
                         (jst_ff == mbrtu_pkg::ST_EXC) ? jexc_ff : 8'd0, 16'd0};
               phase_in = (jst_ff == mbrtu_pkg::ST_OK) ? PH_OK : PH_FAIL;
            end
            st_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; phase_ff <= PH_IDLE; cnt_ff <= '0; crc_ff <= 16'hFFFF;
         sil_ff <= '0; started_ff <= 1'b0; lslave_ff <= '0; lop_ff <= '0;
         laddr_ff <= '0; lcv_ff <= '0; rv_ff <= 1'b0; step_ff <= '0;
         gap_ff <= mbrtu_pkg::FrameGapReset; tmo_ff <= mbrtu_pkg::ReplyTimeoutReset;
      end else begin
         st_ff <= st_in; phase_ff <= phase_in; cnt_ff <= cnt_in; crc_ff <= crc_in;
         sil_ff <= sil_in; started_ff <= started_in; lslave_ff <= lslave_in;
         lop_ff <= lop_in; laddr_ff <= laddr_in; lcv_ff <= lcv_in;
         rv_ff <= rv_in; step_ff <= step_in;
         if (csr.valid) begin
            if (csr.payload.index == mbrtu_pkg::CSR_GAP) gap_ff <= csr.payload.data[15:0];
            else tmo_ff <= csr.payload.data;
         end
      end
      frame_ff <= frame_in; idx_ff <= idx_in; b2_ff <= b2_in; word_ff <= word_in;
      jst_ff <= jst_in; jexc_ff <= jexc_in; rp_ff <= rp_in; rd_idx_ff <= rd_idx_in;
   end

   `ASSERT_CLK(a_rsp_hold, clock, reset, rv_ff && !rsp.ready |=> rv_ff && $stable(rp_ff), "rsp dropped")
   `ASSERT_CLK(a_cnt_bound, clock, reset, cnt_ff <= CW'(RX_BUFFER_DEPTH), "rx count past buffer")
   `ASSERT_CLK(a_busy_noacc, clock, reset, st_ff != S_IDLE |-> !req.ready, "input taken while busy")
   `ASSERT_CLK(a_wr_wait, clock, reset, wr_en |-> phase_ff == PH_WAIT, "byte stored outside a reply")
endmodule
